FILE: rtl/core/adaptive_survey_track_stepper_top_assert.svh
// assertion macros shared by the survey stepper
`ifndef ADAPTIVE_SURVEY_TRACK_STEPPER_TOP_ASSERT_SVH
`define ADAPTIVE_SURVEY_TRACK_STEPPER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ASTS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/asts_pkg.sv
package asts_pkg;

	localparam int INDEX_BITS  = 10;
	localparam int SAMPLE_BITS = 16;
	localparam int SUM_BITS    = SAMPLE_BITS + 16;
	localparam int COUNT_BITS  = 16;
	localparam int PREV_BITS   = INDEX_BITS + 1;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam int DIV_CNT_BITS = $clog2(SUM_BITS);

	localparam logic [INDEX_BITS-1:0] IDX_MAX   = {INDEX_BITS{1'b1}};
	localparam logic [PREV_BITS-1:0]  PREV_NONE = {PREV_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [2:0] {
		MODE_START    = 3'd0,
		MODE_SAMPLE   = 3'd1,
		MODE_LEG_OK   = 3'd2,
		MODE_LEG_FAIL = 3'd3,
		MODE_PREEMPT  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_RUN     = 2'd1,
		PH_DONE    = 2'd2,
		PH_PREEMPT = 2'd3
	} phase_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_QUIET_THRESHOLD = 3'd0,
		CFG_MIN_SECTIONS    = 3'd1,
		CFG_TREND_WINDOW    = 3'd2,
		CFG_START_TRACK     = 3'd3,
		CFG_START_SECTION   = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		SEQ_IDLE = 1'b0,
		SEQ_DIV  = 1'b1
	} seq_state_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

FILE: rtl/core/asts_in_if.sv
interface asts_in_if;
	import asts_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [2:0]             mode;
	logic [SAMPLE_BITS-1:0] sample_value;

	modport source (output valid, output mode, output sample_value, input ready);
	modport sink (input valid, input mode, input sample_value, output ready);

endinterface

FILE: rtl/core/asts_out_if.sv
interface asts_out_if;
	import asts_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [INDEX_BITS-1:0]  track_index;
	logic [INDEX_BITS-1:0]  section_index;
	logic [1:0]             run_status;
	logic                   send_waypoint;
	logic [SAMPLE_BITS-1:0] last_section_average;

	modport source (output valid, output track_index, output section_index,
		output run_status, output send_waypoint, output last_section_average,
		input ready);
	modport sink (input valid, input track_index, input section_index,
		input run_status, input send_waypoint, input last_section_average,
		output ready);

endinterface

FILE: rtl/core/asts_div.sv
module asts_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [asts_pkg::SUM_BITS-1:0]   dividend,
	input  logic [asts_pkg::COUNT_BITS-1:0] divisor,
	output logic [asts_pkg::SUM_BITS-1:0]   quotient,
	output asts_pkg::div_sts_t              sts
);
	import asts_pkg::*;

	logic [COUNT_BITS:0]     rem_q;
	logic [SUM_BITS-1:0]     quo_q;
	logic [COUNT_BITS-1:0]   dsr_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;

	logic [COUNT_BITS:0]     rem_sh;
	logic                    fits;

	// one restoring step: shift in next dividend bit, trial subtract
	always_comb begin
		rem_sh = {rem_q[COUNT_BITS-1:0], quo_q[SUM_BITS-1]};
		fits   = rem_sh >= {1'b0, dsr_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_BITS'(SUM_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, quotient bits shift in where dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
			quo_q <= {quo_q[SUM_BITS-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign sts.busy  = busy_q;
	assign sts.done  = done_q;

endmodule

FILE: rtl/core/adaptive_survey_track_stepper_top.sv
// result word: registered, in the cycle after the accepted word; when a leg success
//   closes a sample window, the 32-step serial divider is loaded, steps and is applied first
// throughput: one word per cycle when no window closes and rsp.ready does not stall the
//   result register; no new word is accepted while the single shared restoring divider runs
// reset: arst_n asynchronous active low, registers at their reset values, phase idle
module adaptive_survey_track_stepper_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [asts_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [asts_pkg::CFG_DATA_BITS-1:0] cfg_data,
	asts_in_if.sink                            req,
	asts_out_if.source                         rsp
);
	import asts_pkg::*;

	`include "adaptive_survey_track_stepper_top_assert.svh"

	// configuration registers
	logic [SAMPLE_BITS-1:0] quiet_threshold_q;
	logic [INDEX_BITS-1:0]  min_sections_q;
	logic [INDEX_BITS-1:0]  trend_window_q;
	logic [INDEX_BITS-1:0]  start_track_q;
	logic [INDEX_BITS-1:0]  start_section_q;

	// survey state
	logic [INDEX_BITS-1:0]  track_q, n_track;
	logic [INDEX_BITS-1:0]  section_q, n_section;
	logic [PREV_BITS-1:0]   prev_q, n_prev;
	logic [SUM_BITS-1:0]    sum_q, n_sum;
	logic [COUNT_BITS-1:0]  count_q, n_count;
	logic                   over_q, n_over;
	logic [INDEX_BITS-1:0]  quiet_q, n_quiet;
	logic [INDEX_BITS-1:0]  falling_q, n_falling;
	logic                   have_avg_q, n_have_avg;
	logic [SAMPLE_BITS-1:0] prior_avg_q, n_prior_avg;
	logic                   all_quiet_q, n_all_quiet;
	logic [INDEX_BITS-1:0]  done_cnt_q, n_done_cnt;
	phase_t                 phase_q, n_phase;

	// sequencer and output register
	seq_state_t             seq_q, seq_d;
	logic                   out_valid_q;
	logic                   send_q, n_send;

	logic                   acc;
	logic                   div_go;
	logic                   fin;
	logic                   close_c;
	logic                   leg_c;
	logic                   turn;
	logic [SAMPLE_BITS-1:0] avg;
	logic [SUM_BITS-1:0]    quotient;
	div_sts_t               div_sts;

	assign req.ready = (seq_q == SEQ_IDLE) && (!out_valid_q || rsp.ready);
	assign acc       = req.valid && req.ready;
	assign div_go    = acc && (req.mode == MODE_LEG_OK) && (phase_q == PH_RUN) &&
		(prev_q == {1'b0, track_q});
	assign fin       = (seq_q == SEQ_DIV) && div_sts.done;

	asts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (sum_q),
		.divisor  (count_q),
		.quotient (quotient),
		.sts      (div_sts)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_threshold_q <= SAMPLE_BITS'(32768);
			min_sections_q    <= INDEX_BITS'(2);
			trend_window_q    <= INDEX_BITS'(3);
			start_track_q     <= '0;
			start_section_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_QUIET_THRESHOLD: quiet_threshold_q <= cfg_data[SAMPLE_BITS-1:0];
				CFG_MIN_SECTIONS:    min_sections_q    <= cfg_data[INDEX_BITS-1:0];
				CFG_TREND_WINDOW:    trend_window_q    <= cfg_data[INDEX_BITS-1:0];
				CFG_START_TRACK:     start_track_q     <= cfg_data[INDEX_BITS-1:0];
				CFG_START_SECTION:   start_section_q   <= cfg_data[INDEX_BITS-1:0];
				default: ;
			endcase
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_IDLE;
		end else begin
			seq_q <= seq_d;
		end
	end

	// sequencer next state
	always_comb begin
		seq_d = seq_q;
		case (seq_q)
			SEQ_IDLE: if (div_go) seq_d = SEQ_DIV;
			SEQ_DIV:  if (div_sts.done) seq_d = SEQ_IDLE;
			default:  seq_d = SEQ_IDLE;
		endcase
	end

	// next survey state: mode handling, then window close, then leg step
	always_comb begin
		n_track     = track_q;
		n_section   = section_q;
		n_prev      = prev_q;
		n_sum       = sum_q;
		n_count     = count_q;
		n_over      = over_q;
		n_quiet     = quiet_q;
		n_falling   = falling_q;
		n_have_avg  = have_avg_q;
		n_prior_avg = prior_avg_q;
		n_all_quiet = all_quiet_q;
		n_done_cnt  = done_cnt_q;
		n_phase     = phase_q;
		n_send      = 1'b0;
		close_c     = 1'b0;
		leg_c       = 1'b0;
		turn        = 1'b0;
		avg         = (count_q == '0) ? '0 : quotient[SAMPLE_BITS-1:0];

		if (fin) begin
			close_c = 1'b1;
			leg_c   = 1'b1;
		end else if (acc && !div_go) begin
			case (req.mode)
				MODE_START: begin
					n_track     = start_track_q;
					n_section   = start_section_q;
					n_prev      = {1'b0, start_track_q} - PREV_BITS'(1);
					n_sum       = '0;
					n_count     = '0;
					n_over      = 1'b0;
					n_prior_avg = '0;
					n_quiet     = '0;
					n_falling   = '0;
					n_have_avg  = 1'b0;
					n_all_quiet = 1'b1;
					n_done_cnt  = '0;
					n_phase     = PH_RUN;
					n_send      = 1'b1;
				end
				MODE_SAMPLE: begin
					if (phase_q == PH_RUN) begin
						if (req.sample_value >= quiet_threshold_q) n_over = 1'b1;
						if (count_q != COUNT_MAX) begin
							n_sum   = sum_q + SUM_BITS'(req.sample_value);
							n_count = count_q + 1'b1;
						end
					end
				end
				MODE_LEG_OK: begin
					if (phase_q == PH_RUN) leg_c = 1'b1;
				end
				MODE_LEG_FAIL: begin
					if (phase_q == PH_RUN) n_send = 1'b1;
				end
				MODE_PREEMPT: begin
					if (phase_q == PH_RUN) begin
						n_all_quiet = 1'b0;
						n_phase     = PH_PREEMPT;
					end
				end
				default: ;
			endcase
		end

		// close the sample window
		if (close_c) begin
			if (have_avg_q && (prior_avg_q >= avg)) begin
				n_falling = (falling_q == IDX_MAX) ? IDX_MAX : falling_q + 1'b1;
			end else begin
				n_falling = '0;
			end
			n_have_avg  = 1'b1;
			n_prior_avg = avg;
			if (over_q) begin
				n_all_quiet = 1'b0;
				n_quiet     = '0;
			end else begin
				n_quiet = (quiet_q == IDX_MAX) ? IDX_MAX : quiet_q + 1'b1;
			end
			n_sum   = '0;
			n_count = '0;
			n_over  = 1'b0;
		end

		// step along the track or turn to the next one
		if (leg_c) begin
			n_prev = {1'b0, track_q};
			turn = (n_done_cnt >= min_sections_q) && (n_quiet >= trend_window_q) &&
				((trend_window_q == '0) || (n_falling >= trend_window_q - 1'b1));
			if (turn || (track_q[0] && (section_q == '0))) begin
				n_track = (track_q == IDX_MAX) ? IDX_MAX : track_q + 1'b1;
				if (n_all_quiet) begin
					n_phase = PH_DONE;
				end else begin
					n_quiet     = '0;
					n_falling   = '0;
					n_have_avg  = 1'b0;
					n_all_quiet = 1'b1;
					n_done_cnt  = '0;
				end
			end else begin
				if (!track_q[0]) begin
					n_section = (section_q == IDX_MAX) ? IDX_MAX : section_q + 1'b1;
				end else if (section_q != '0) begin
					n_section = section_q - 1'b1;
				end
				n_done_cnt = (n_done_cnt == IDX_MAX) ? IDX_MAX : n_done_cnt + 1'b1;
			end
			n_send = (n_phase == PH_RUN);
		end
	end

	// survey state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q     <= '0;
			section_q   <= '0;
			prev_q      <= PREV_NONE;
			sum_q       <= '0;
			count_q     <= '0;
			over_q      <= 1'b0;
			quiet_q     <= '0;
			falling_q   <= '0;
			have_avg_q  <= 1'b0;
			prior_avg_q <= '0;
			all_quiet_q <= 1'b1;
			done_cnt_q  <= '0;
			phase_q     <= PH_IDLE;
		end else if (fin || (acc && !div_go)) begin
			track_q     <= n_track;
			section_q   <= n_section;
			prev_q      <= n_prev;
			sum_q       <= n_sum;
			count_q     <= n_count;
			over_q      <= n_over;
			quiet_q     <= n_quiet;
			falling_q   <= n_falling;
			have_avg_q  <= n_have_avg;
			prior_avg_q <= n_prior_avg;
			all_quiet_q <= n_all_quiet;
			done_cnt_q  <= n_done_cnt;
			phase_q     <= n_phase;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			send_q      <= 1'b0;
		end else begin
			if (fin || (acc && !div_go)) begin
				out_valid_q <= 1'b1;
				send_q      <= n_send;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid                = out_valid_q;
	assign rsp.track_index          = track_q;
	assign rsp.section_index        = section_q;
	assign rsp.run_status           = phase_q;
	assign rsp.send_waypoint        = send_q;
	assign rsp.last_section_average = prior_avg_q;

	// checks
	`ASTS_ASSERT_SAME(a_no_accept_in_div, seq_q == SEQ_DIV, !req.ready, "accept while dividing")
	`ASTS_ASSERT_SAME(a_done_in_div, div_sts.done, seq_q == SEQ_DIV, "divider done outside div")
	`ASTS_ASSERT_NEXT(a_div_starts, div_go, (seq_q == SEQ_DIV) && div_sts.busy, "divider not started")
	`ASTS_ASSERT_SAME(a_no_result_in_div, seq_q == SEQ_DIV, !out_valid_q, "result pending in div")
	`ASTS_ASSERT_SAME(a_send_when_run, rsp.valid && rsp.send_waypoint, phase_q == PH_RUN,
		"waypoint outside running phase")

endmodule
